// File: sv/hkrb_pkg.sv
// ----------------------------------------------------------------------------
// hkrb_pkg
// Shared types and constants for the boot keyboard report builder.
// ----------------------------------------------------------------------------
`default_nettype none

package hkrb_pkg;

	// Key code width and pressed map depth
	localparam int CODE_W       = 8;
	localparam int CODE_COUNT   = 256;
	localparam int ADDR_W       = (CODE_COUNT > 1) ? $clog2(CODE_COUNT) : 1;

	// Held key slots and the slots shown in the report
	localparam int SLOT_COUNT   = 6;
	localparam int REPORT_SLOTS = 6;

	typedef logic [CODE_W-1:0] code_t;

	// Input word: one key event
	typedef struct packed {
		logic [7:0] key_code;
		logic       is_press;
		logic       is_modifier;
	} in_word_t;

	// Output word: the full boot report plus overflow flag
	typedef struct packed {
		logic [7:0] modifier_bits;
		logic [7:0] slot_zero;
		logic [7:0] slot_one;
		logic [7:0] slot_two;
		logic [7:0] slot_three;
		logic [7:0] slot_four;
		logic [7:0] slot_five;
		logic       overflow;
	} out_word_t;

	// Update command from the controller to the report state
	typedef struct packed {
		logic       apply;
		logic       is_press;
		logic       is_modifier;
		code_t      code;
	} rep_cmd_t;

	// Controller states
	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_EVAL
	} ctrl_state_t;

endpackage

`default_nettype wire

// File: sv/hkrb_map_mem.sv
// ----------------------------------------------------------------------------
// hkrb_map_mem
// Pressed map: one bit per key code, with a registered synchronous read.
// ----------------------------------------------------------------------------
`default_nettype none

module hkrb_map_mem
	import hkrb_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              we,
	input  wire logic [ADDR_W-1:0] waddr,
	input  wire logic              wdata,
	input  wire logic              re,
	input  wire logic [ADDR_W-1:0] raddr,
	output logic                   rdata
);

	logic mem [CODE_COUNT];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port; hold the data until the next read
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

// File: sv/hkrb_report.sv
// ----------------------------------------------------------------------------
// hkrb_report
// Modifier byte and key slots: compute the next report and commit it on apply.
// ----------------------------------------------------------------------------
`default_nettype none

module hkrb_report
	import hkrb_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire rep_cmd_t  cmd,
	output out_word_t      report
);

	code_t             slots_q [SLOT_COUNT];
	code_t             slots_nxt [SLOT_COUNT];
	logic [7:0]        mod_q;
	logic [7:0]        mod_nxt;
	logic              full;
	code_t             rep [REPORT_SLOTS];

	// Next slot contents: fill first empty slot on press, close the gap on release
	always_comb begin
		logic seen_zero;
		logic seen_match;
		seen_zero  = 1'b0;
		seen_match = 1'b0;
		full       = 1'b0;
		for (int i = 0; i < SLOT_COUNT; i++) begin
			slots_nxt[i] = slots_q[i];
			if (!cmd.is_modifier) begin
				if (cmd.is_press) begin
					if (!seen_zero && slots_q[i] == '0) begin
						slots_nxt[i] = cmd.code;
						seen_zero    = 1'b1;
					end
				end else begin
					if (slots_q[i] == cmd.code) begin
						seen_match = 1'b1;
					end
					if (seen_match) begin
						if (i < SLOT_COUNT - 1) begin
							slots_nxt[i] = slots_q[i+1];
						end else begin
							slots_nxt[i] = '0;
						end
					end
				end
			end
		end
		if (!cmd.is_modifier && cmd.is_press && !seen_zero) begin
			full = 1'b1;
		end
	end

	// Next modifier byte: set or clear the mask bits
	always_comb begin
		mod_nxt = mod_q;
		if (cmd.is_modifier) begin
			if (cmd.is_press) begin
				mod_nxt = mod_q | cmd.code;
			end else begin
				mod_nxt = mod_q & ~cmd.code;
			end
		end
	end

	// Commit the update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mod_q <= '0;
			for (int i = 0; i < SLOT_COUNT; i++) begin
				slots_q[i] <= '0;
			end
		end else if (cmd.apply) begin
			mod_q <= mod_nxt;
			for (int i = 0; i < SLOT_COUNT; i++) begin
				slots_q[i] <= slots_nxt[i];
			end
		end
	end

	// Report slots past the held slots read as empty
	always_comb begin
		for (int i = 0; i < REPORT_SLOTS; i++) begin
			rep[i] = '0;
			if (i < SLOT_COUNT) begin
				rep[i] = slots_nxt[i];
			end
		end
	end

	assign report.modifier_bits = mod_nxt;
	assign report.slot_zero     = rep[0];
	assign report.slot_one      = rep[1];
	assign report.slot_two      = rep[2];
	assign report.slot_three    = rep[3];
	assign report.slot_four     = rep[4];
	assign report.slot_five     = rep[5];
	assign report.overflow      = full;

endmodule

`default_nettype wire

// File: sv/hid_keyboard_report_builder.sv
// ----------------------------------------------------------------------------
// hid_keyboard_report_builder
// Six-key-rollover boot keyboard report builder with a pressed-key map.
// ----------------------------------------------------------------------------
// After reset the block sweeps the 256-entry pressed map to zero, one entry a
// cycle, and in_ready stays low until the sweep is done. Each key event then
// takes two steps: one to read its pressed mark from the map memory and one
// to compare, write the mark back and build the report; the next event is
// taken once the controller is back in idle. A repeated press or release
// gives no output word. Other events give one word holding the whole report,
// held in an output register so that the next event can be taken while it
// waits. An event that gives a word while that register still holds a word
// not yet taken stays in its second step, with in_ready low, until out_ready
// frees the register.
`default_nettype none

module hid_keyboard_report_builder
	import hkrb_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      in_valid,
	output logic           in_ready,
	input  wire in_word_t  in_word,
	output logic           out_valid,
	input  wire logic      out_ready,
	output out_word_t      out_word
);

	ctrl_state_t       state_q;
	ctrl_state_t       state_nxt;
	logic [ADDR_W-1:0] clr_cnt_q;
	in_word_t          item_s1;
	logic              out_valid_q;
	out_word_t         out_word_q;

	logic              mem_we;
	logic [ADDR_W-1:0] mem_waddr;
	logic              mem_wdata;
	logic              mem_re;
	logic              mark_s1;
	logic              in_map_s1;
	logic              out_free;
	logic              load_out;
	rep_cmd_t          cmd;
	out_word_t         report;

	hkrb_map_mem u_map (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (in_word.key_code[ADDR_W-1:0]),
		.rdata (mark_s1)
	);

	hkrb_report u_report (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.report (report)
	);

	assign in_map_s1 = {1'b0, item_s1.key_code} < (CODE_W + 1)'(CODE_COUNT);
	assign out_free  = !out_valid_q || out_ready;

	// Next state and control
	always_comb begin
		state_nxt   = state_q;
		in_ready    = 1'b0;
		mem_re      = 1'b0;
		mem_we      = 1'b0;
		mem_waddr   = item_s1.key_code[ADDR_W-1:0];
		mem_wdata   = item_s1.is_press;
		load_out    = 1'b0;
		unique case (state_q)
			ST_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_cnt_q;
				mem_wdata = 1'b0;
				if (clr_cnt_q == ADDR_W'(CODE_COUNT - 1)) begin
					state_nxt = ST_IDLE;
				end
			end
			ST_IDLE: begin
				in_ready = 1'b1;
				mem_re   = in_valid;
				if (in_valid) begin
					state_nxt = ST_EVAL;
				end
			end
			ST_EVAL: begin
				// Drop repeats and codes outside the map
				if (!in_map_s1 || mark_s1 == item_s1.is_press) begin
					state_nxt = ST_IDLE;
				end else if (out_free) begin
					mem_we    = 1'b1;
					load_out  = 1'b1;
					state_nxt = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	assign cmd.apply       = load_out;
	assign cmd.is_press    = item_s1.is_press;
	assign cmd.is_modifier = item_s1.is_modifier;
	assign cmd.code        = item_s1.key_code;

	// Controller state and clear counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_CLEAR;
			clr_cnt_q <= '0;
		end else begin
			state_q <= state_nxt;
			if (state_q == ST_CLEAR) begin
				clr_cnt_q <= clr_cnt_q + 1'b1;
			end
		end
	end

	// Hold the accepted event while its mark is read
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= in_word;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_word_q <= report;
		end
	end

	assign out_valid = out_valid_q;
	assign out_word  = out_word_q;

endmodule

`default_nettype wire

// File: tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the boot keyboard report builder.
// ----------------------------------------------------------------------------
// A queue of key events is built up front: a short directed run through the
// corner cases (repeats, shared press marks, full slots, key code zero), then
// mostly well-formed press/release traffic with some repeated events mixed
// in. A clocked driver offers the words and runs a model of the report state
// on each accepted event. A clocked monitor compares every report word with
// the oldest prediction. Idling on both sides changes in three phases, and
// the receiver holds off once for a long stretch so that the block stalls.

module tb_top;
	import hkrb_pkg::*;

	localparam int LIVE_EVENTS = 960;
	localparam int LONG_HOLD   = 150;
	localparam int SETTLE      = 16;
	localparam int N_FIELDS    = 8;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      in_valid = 1'b0;
	logic      in_ready;
	in_word_t  in_word = '0;
	logic      out_valid;
	logic      out_ready = 1'b0;
	out_word_t out_word;

	hid_keyboard_report_builder dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_word  (in_word),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_word (out_word)
	);

	initial forever #4 clk = ~clk;

	// ------------------------------------------------------------------------
	// Stimulus planning: shadow of what is held, used only to shape traffic
	// ------------------------------------------------------------------------
	typedef struct {
		code_t code;
		bit    modk;
	} held_key_t;

	in_word_t  event_q[$];
	bit        plan_down [CODE_COUNT];
	held_key_t plan_held[$];
	int        total_events;

	// Queue one event and track the held set it leaves behind
	task automatic post_event(input code_t code, input bit press, input bit modk,
			output bit live);
		in_word_t w;
		int       idx;
		w.key_code    = code;
		w.is_press    = press;
		w.is_modifier = modk;
		event_q.push_back(w);
		live = (plan_down[code] != press);
		if (live) begin
			plan_down[code] = press;
			if (press) begin
				plan_held.push_back('{code, modk});
			end else begin
				idx = -1;
				foreach (plan_held[i])
					if (idx < 0 && plan_held[i].code == code)
						idx = i;
				if (idx >= 0)
					plan_held.delete(idx);
			end
		end
	endtask

	// Mostly a small pool so that codes collide, sometimes any code or one bit
	function automatic code_t pick_code();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return code_t'($urandom_range(0, 19));
		else if (r < 75)
			return code_t'(1 << $urandom_range(0, 7));
		else
			return code_t'($urandom_range(0, 255));
	endfunction

	// ------------------------------------------------------------------------
	// Report model and expected words
	// ------------------------------------------------------------------------
	bit        down_map [CODE_COUNT];
	code_t     mod_byte;
	code_t     slot_codes [SLOT_COUNT];
	out_word_t report_q[$];
	int        n_reports, n_dropped, n_overflow, n_mod_updates;

	function automatic code_t slot_at(input int i);
		return (i < SLOT_COUNT && i < REPORT_SLOTS) ? slot_codes[i] : '0;
	endfunction

	// Apply one key event; return 1 with the new report if it is not dropped
	function automatic bit apply_key_event(input in_word_t w, output out_word_t rpt);
		bit full;
		int hit;
		full = 1'b0;
		rpt  = '0;
		if (int'(w.key_code) >= CODE_COUNT)
			return 1'b0;
		if (down_map[w.key_code] == w.is_press)
			return 1'b0;
		down_map[w.key_code] = w.is_press;
		if (w.is_modifier) begin
			if (w.is_press)
				mod_byte = mod_byte | w.key_code;
			else
				mod_byte = mod_byte & ~w.key_code;
		end else if (w.is_press) begin
			// fill the first empty slot, else flag overflow
			full = 1'b1;
			for (int i = 0; i < SLOT_COUNT; i++) begin
				if (full && slot_codes[i] == '0) begin
					slot_codes[i] = w.key_code;
					full = 1'b0;
				end
			end
		end else begin
			// drop the first matching slot and close the gap
			hit = -1;
			for (int i = 0; i < SLOT_COUNT; i++)
				if (hit < 0 && slot_codes[i] == w.key_code)
					hit = i;
			if (hit >= 0) begin
				for (int j = hit; j < SLOT_COUNT - 1; j++)
					slot_codes[j] = slot_codes[j + 1];
				slot_codes[SLOT_COUNT - 1] = '0;
			end
		end
		rpt.modifier_bits = mod_byte;
		rpt.slot_zero     = slot_at(0);
		rpt.slot_one      = slot_at(1);
		rpt.slot_two      = slot_at(2);
		rpt.slot_three    = slot_at(3);
		rpt.slot_four     = slot_at(4);
		rpt.slot_five     = slot_at(5);
		rpt.overflow      = full;
		return 1'b1;
	endfunction

	// ------------------------------------------------------------------------
	// Idling phases, chosen by progress through the event list
	// ------------------------------------------------------------------------
	int events_taken;

	function automatic int run_phase();
		if (total_events == 0)
			return 0;
		return (events_taken * 3) / total_events;
	endfunction

	function automatic int send_idle_pct();
		case (run_phase())
			0:       return 23;
			1:       return 81;
			default: return 0;
		endcase
	endfunction

	function automatic int recv_idle_pct();
		case (run_phase())
			0:       return 81;
			1:       return 23;
			default: return 0;
		endcase
	endfunction

	// ------------------------------------------------------------------------
	// Driver: offer queued words, predict on each accepted one
	// ------------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		bit        taken;
		bit        made;
		out_word_t rpt;
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_word  <= '0;
		end else begin
			taken = in_valid && in_ready;
			if (taken) begin
				made = apply_key_event(in_word, rpt);
				if (made) begin
					report_q.push_back(rpt);
					n_reports++;
					if (rpt.overflow)
						n_overflow++;
					if (in_word.is_modifier)
						n_mod_updates++;
				end else begin
					n_dropped++;
				end
				events_taken++;
			end
			// hold the word until taken, then load the next or idle
			if (!in_valid || taken) begin
				if (event_q.size() > 0 && $urandom_range(0, 99) >= send_idle_pct()) begin
					in_word  <= event_q.pop_front();
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// ------------------------------------------------------------------------
	// Monitor: check report words, drive ready with one long hold-off
	// ------------------------------------------------------------------------
	string field_name [N_FIELDS] = '{"modifier_bits", "slot_zero", "slot_one",
		"slot_two", "slot_three", "slot_four", "slot_five", "overflow"};
	int    fail_count;
	int    hold_left;
	bit    hold_done;

	function automatic logic [7:0] report_field(input out_word_t w, input int i);
		case (i)
			0:       return w.modifier_bits;
			1:       return w.slot_zero;
			2:       return w.slot_one;
			3:       return w.slot_two;
			4:       return w.slot_three;
			5:       return w.slot_four;
			6:       return w.slot_five;
			default: return {7'b0, w.overflow};
		endcase
	endfunction

	always @(posedge clk or negedge arst_n) begin
		out_word_t want;
		if (!arst_n) begin
			out_ready <= 1'b0;
			hold_left <= 0;
			hold_done <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (report_q.size() == 0) begin
					$error("report word with no event pending: %h", out_word);
					fail_count++;
				end else begin
					want = report_q.pop_front();
					for (int i = 0; i < N_FIELDS; i++) begin
						if (report_field(out_word, i) !== report_field(want, i)) begin
							$error("%s: expected %0h, got %0h", field_name[i],
								report_field(want, i), report_field(out_word, i));
							fail_count++;
						end
					end
				end
			end
			// long stall once the sender runs flat out, random ready otherwise
			if (hold_left > 0) begin
				hold_left <= hold_left - 1;
				out_ready <= 1'b0;
			end else if (!hold_done && run_phase() >= 2) begin
				hold_left <= LONG_HOLD;
				hold_done <= 1'b1;
				out_ready <= 1'b0;
			end else begin
				out_ready <= ($urandom_range(0, 99) >= recv_idle_pct());
			end
		end
	end

	// ------------------------------------------------------------------------
	// Event list, reset and end of run
	// ------------------------------------------------------------------------
	initial begin
		bit        live;
		int        live_n;
		int        r;
		int        idx;
		int        tries;
		code_t     code;
		held_key_t h;

		// directed: repeats, shared marks, full slots, code zero, releases
		post_event(8'h04, 1'b1, 1'b0, live);
		post_event(8'h04, 1'b1, 1'b0, live);
		post_event(8'h05, 1'b0, 1'b0, live);
		post_event(8'h02, 1'b1, 1'b1, live);
		post_event(8'hFF, 1'b1, 1'b1, live);
		post_event(8'h02, 1'b1, 1'b0, live);
		post_event(8'h05, 1'b1, 1'b0, live);
		post_event(8'h06, 1'b1, 1'b0, live);
		post_event(8'h07, 1'b1, 1'b0, live);
		post_event(8'h08, 1'b1, 1'b0, live);
		post_event(8'h09, 1'b1, 1'b0, live);
		post_event(8'hFE, 1'b1, 1'b0, live);
		post_event(8'h06, 1'b0, 1'b0, live);
		post_event(8'h00, 1'b1, 1'b0, live);
		post_event(8'h0A, 1'b1, 1'b0, live);
		post_event(8'hFE, 1'b0, 1'b0, live);
		post_event(8'h00, 1'b0, 1'b0, live);
		post_event(8'h02, 1'b0, 1'b1, live);
		post_event(8'hFF, 1'b0, 1'b1, live);
		post_event(8'h04, 1'b0, 1'b0, live);
		post_event(8'h0A, 1'b0, 1'b0, live);

		// random: mostly real presses and releases, some repeated events
		live_n = 0;
		while (live_n < LIVE_EVENTS) begin
			r = $urandom_range(0, 99);
			if (r < 12) begin
				code = pick_code();
				post_event(code, plan_down[code], 1'($urandom_range(0, 1)), live);
			end else if (plan_held.size() == 0 ||
					(plan_held.size() < 9 && $urandom_range(0, 99) < 55)) begin
				code  = pick_code();
				tries = 0;
				while (plan_down[code] && tries < 8) begin
					code = pick_code();
					tries++;
				end
				post_event(code, 1'b1, $urandom_range(0, 99) < 15, live);
			end else begin
				idx = $urandom_range(0, plan_held.size() - 1);
				h   = plan_held[idx];
				post_event(h.code, 1'b0,
					($urandom_range(0, 99) < 8) ? !h.modk : h.modk, live);
			end
			if (live)
				live_n++;
		end
		total_events = event_q.size();

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// wait for every event to be taken and every report to arrive
		while (events_taken < total_events || report_q.size() > 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);

		$display("Ran %0d key events: %0d reports, %0d dropped repeats, %0d overflows,",
			total_events, n_reports, n_dropped, n_overflow);
		$display("%0d modifier updates, three idling phases and one long output stall.",
			n_mod_updates);
		if (fail_count == 0 && report_q.size() == 0)
			$display("hid_keyboard_report_builder verification clean");
		else
			$display("hid_keyboard_report_builder verification failed");
		$finish;
	end

	// Guard against a hung handshake
	initial begin
		#2_000_000;
		$display("hid_keyboard_report_builder verification failed");
		$finish;
	end

endmodule
